// ----- src/fjpt_pkg.sv -----
package fjpt_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key_offset;
    logic [15:0] key_length;
    logic [15:0] value_offset;
    logic [15:0] value_length;
    logic [15:0] pair_index;
  } result_word_t;

  localparam logic [1:0] KIND_PAIR  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam logic [15:0] PAIR_MAX = 16'hFFFF;

endpackage

// ----- src/fjpt_parser.sv -----
module fjpt_parser #(
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  fjpt_pkg::byte_word_t  word,
  output logic                  emit,
  output fjpt_pkg::result_word_t result
);
  import fjpt_pkg::*;

  localparam int P = POSITION_BITS;
  localparam logic [P-1:0] PosMax = '1;

  localparam logic [3:0] ST_OPEN      = 4'd0;
  localparam logic [3:0] ST_KEY_WAIT  = 4'd1;
  localparam logic [3:0] ST_KEY_START = 4'd2;
  localparam logic [3:0] ST_KEY       = 4'd3;
  localparam logic [3:0] ST_KEY_END   = 4'd4;
  localparam logic [3:0] ST_VAL_WAIT  = 4'd5;
  localparam logic [3:0] ST_VAL_START = 4'd6;
  localparam logic [3:0] ST_VALUE     = 4'd7;
  localparam logic [3:0] ST_VAL_END   = 4'd8;
  localparam logic [3:0] ST_DONE      = 4'd9;
  localparam logic [3:0] ST_HALT      = 4'd10;
  localparam logic [3:0] ST_ERR       = 4'd11;

  logic [3:0]   parse_state, parse_state_next;
  logic [P-1:0] byte_position, byte_position_next;
  logic [P-1:0] cur_key_offset, cur_key_offset_next;
  logic [P-1:0] cur_key_length, cur_key_length_next;
  logic [P-1:0] cur_value_offset, cur_value_offset_next;
  logic [P-1:0] cur_value_length, cur_value_length_next;
  logic [15:0]  pairs_seen, pairs_seen_next;

  logic [3:0]   st_e;
  logic [P-1:0] pos_e, ko_e, kl_e, vo_e, vl_e;
  logic [15:0]  pairs_e;
  logic [3:0]   ns;
  logic         blank, halted, is_err, is_done, is_trunc;

  always_comb begin
    if (word.first) begin
      st_e    = ST_OPEN;
      pos_e   = '0;
      ko_e    = '0;
      kl_e    = '0;
      vo_e    = '0;
      vl_e    = '0;
      pairs_e = '0;
    end else begin
      st_e    = parse_state;
      pos_e   = byte_position;
      ko_e    = cur_key_offset;
      kl_e    = cur_key_length;
      vo_e    = cur_value_offset;
      vl_e    = cur_value_length;
      pairs_e = pairs_seen;
    end
  end

  assign halted = (st_e == ST_DONE) || (st_e == ST_HALT) || (st_e == ST_ERR);
  assign blank  = (word.data_byte inside {CH_SPACE, CH_TAB, CH_NL});

  always_comb begin
    if (st_e != ST_KEY && st_e != ST_VALUE && blank) begin
      ns = st_e;
    end else begin
      case (st_e)
        ST_OPEN:      ns = (word.data_byte == CH_LBRACE) ? ST_KEY_WAIT : ST_ERR;
        ST_KEY_WAIT:  ns = (word.data_byte == CH_QUOTE) ? ST_KEY_START : ST_ERR;
        ST_VAL_WAIT:  ns = (word.data_byte == CH_QUOTE) ? ST_VAL_START : ST_ERR;
        ST_KEY_START,
        ST_KEY:       ns = (word.data_byte == CH_QUOTE) ? ST_KEY_END : ST_KEY;
        ST_VAL_START,
        ST_VALUE:     ns = (word.data_byte == CH_QUOTE) ? ST_VAL_END : ST_VALUE;
        ST_KEY_END:   ns = (word.data_byte == CH_COLON) ? ST_VAL_WAIT : ST_ERR;
        ST_VAL_END: begin
          if (word.data_byte == CH_RBRACE) begin
            ns = ST_DONE;
          end else if (word.data_byte == CH_COMMA) begin
            ns = ST_KEY_WAIT;
          end else begin
            ns = ST_ERR;
          end
        end
        default:      ns = ST_ERR;
      endcase
    end
  end

  assign is_err   = (ns == ST_ERR);
  assign is_done  = (ns == ST_DONE);
  assign is_trunc = word.last && !is_err && !is_done;
  assign emit     = !halted && (is_err || is_done || is_trunc || ns == ST_VAL_END);

  always_comb begin
    byte_position_next    = (pos_e == PosMax) ? pos_e : pos_e + P'(1);
    parse_state_next      = ns;
    cur_key_offset_next   = ko_e;
    cur_key_length_next   = kl_e;
    cur_value_offset_next = vo_e;
    cur_value_length_next = vl_e;
    pairs_seen_next       = pairs_e;
    if (is_err || is_trunc) begin
      parse_state_next = ST_HALT;
    end else if (is_done) begin
      parse_state_next = ST_DONE;
    end else if (ns == ST_KEY) begin
      if (kl_e == '0) begin
        cur_key_offset_next = pos_e;
      end
      if (kl_e != PosMax) begin
        cur_key_length_next = kl_e + P'(1);
      end
    end else if (ns == ST_VALUE) begin
      if (vl_e == '0) begin
        cur_value_offset_next = pos_e;
      end
      if (vl_e != PosMax) begin
        cur_value_length_next = vl_e + P'(1);
      end
    end else if (ns == ST_VAL_END) begin
      if (pairs_e != PAIR_MAX) begin
        pairs_seen_next = pairs_e + 16'd1;
      end
      cur_key_offset_next   = '0;
      cur_key_length_next   = '0;
      cur_value_offset_next = '0;
      cur_value_length_next = '0;
    end
  end

  always_comb begin
    result              = '0;
    result.pair_index   = pairs_e;
    if (is_err) begin
      result.kind = KIND_ERROR;
    end else if (is_done) begin
      result.kind = KIND_DONE;
    end else if (is_trunc) begin
      result.kind = KIND_TRUNC;
    end else begin
      result.kind         = KIND_PAIR;
      result.key_offset   = 16'(ko_e);
      result.key_length   = 16'(kl_e);
      result.value_offset = 16'(vo_e);
      result.value_length = 16'(vl_e);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state      <= ST_OPEN;
      byte_position    <= '0;
      cur_key_offset   <= '0;
      cur_key_length   <= '0;
      cur_value_offset <= '0;
      cur_value_length <= '0;
      pairs_seen       <= '0;
    end else if (step && !halted) begin
      parse_state      <= parse_state_next;
      byte_position    <= byte_position_next;
      cur_key_offset   <= cur_key_offset_next;
      cur_key_length   <= cur_key_length_next;
      cur_value_offset <= cur_value_offset_next;
      cur_value_length <= cur_value_length_next;
      pairs_seen       <= pairs_seen_next;
    end
  end

endmodule

// ----- src/fjpt_out_reg.sv -----
module fjpt_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  fjpt_pkg::result_word_t load_word,
  output logic                   space,
  output logic                   valid,
  input  logic                   ready,
  output fjpt_pkg::result_word_t word
);
  import fjpt_pkg::*;

  assign space = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end
  end

endmodule

// ----- src/flat_json_pair_tokenizer.sv -----
// Flat JSON pair tokenizer.
// The byte channel (byte_valid, byte_ready, byte_word) takes one byte of a
// flat JSON object per word, with first marking the start of a document and
// last marking the end of the buffer. The result channel (result_valid,
// result_ready, result_word) gives one word for each completed pair, for the
// closing brace, for a syntax error and for a buffer that ends early.
// A byte passes through an input register and is parsed by the state logic;
// its result is then loaded into the output register, from which it is offered.
// One byte is taken every cycle while the result channel keeps up; the rate
// is set by the state update of the parser.
// Reset clears the parser state, the byte position, the pair count and the
// valid flags of both registers; no word is held afterwards.
// When the receiver stalls, the pending result stays in the output register
// and bytes that give no result still flow; byte_ready falls only when a
// byte that gives a result meets a full output register.
module flat_json_pair_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  fjpt_pkg::byte_word_t   byte_word,
  output logic                   result_valid,
  input  logic                   result_ready,
  output fjpt_pkg::result_word_t result_word
);
  import fjpt_pkg::*;

  logic         byte_q_valid;
  byte_word_t   byte_q;
  logic         advance;
  logic         emit;
  logic         space;
  result_word_t parsed;

  assign advance    = byte_q_valid && (!emit || space);
  assign byte_ready = !byte_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_q_valid <= 1'b0;
    end else if (byte_ready) begin
      byte_q_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      byte_q <= byte_word;
    end
  end

  fjpt_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .word   (byte_q),
    .emit   (emit),
    .result (parsed)
  );

  fjpt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .load_word (parsed),
    .space     (space),
    .valid     (result_valid),
    .ready     (result_ready),
    .word      (result_word)
  );

endmodule

// ----- src/fjpt_checker.sv -----
module fjpt_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   byte_ready,
  input logic                   result_valid,
  input logic                   result_ready,
  input fjpt_pkg::result_word_t result_word
);
  import fjpt_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_word))
    else $error("Stalled result word changed or was dropped.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("Result offered straight after reset.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> byte_ready)
    else $error("Byte channel stalled while the output register is empty.");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.kind != KIND_PAIR |->
      result_word.key_offset == 16'd0 && result_word.key_length == 16'd0 &&
      result_word.value_offset == 16'd0 && result_word.value_length == 16'd0)
    else $error("Status word carries pair fields.");

endmodule

bind flat_json_pair_tokenizer fjpt_checker u_fjpt_checker (.*);
